// ===== rtl/cttm_pkg.sv =====
// cttm_pkg: shared types, codes and the tag colour table
// for the cluster/tag colour matcher; no dependencies
`timescale 1ns / 1ps
package cttm_pkg;

  localparam int POS_W        = 18;
  localparam int ID_W         = 10;
  localparam int TIME_W       = 32;
  localparam int TOL_W        = 17;
  localparam int CMD_W        = 2;
  localparam int RGB_W        = 24;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;
  localparam int DEF_TAG_SLOTS = 16;
  localparam int DEF_MAX_POINTS = 65536;

  localparam logic [CMD_W-1:0] CMD_POINT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TAG   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY     = 2'd1;

  localparam logic [TOL_W-1:0]  TOL_RESET   = 17'd250;
  localparam logic [TIME_W-1:0] DECAY_RESET = 32'd2000;
  localparam logic [RGB_W-1:0]  WHITE_RGB   = 24'hFFFFFF;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [ID_W-1:0]          tag_id;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [TIME_W-1:0]        now_ms;
    logic                     last_point;
  } item_t;

  typedef struct packed {
    logic [TOL_W-1:0]  tolerance;
    logic [TIME_W-1:0] decay;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAG_SCAN,
    ST_SWEEP,
    ST_DIV,
    ST_MATCH_MUL,
    ST_MATCH_ACC,
    ST_OUT
  } state_t;

  function automatic logic [RGB_W-1:0] colour_of(input logic [ID_W-1:0] id);
    logic [RGB_W-1:0] rgb;
    rgb = WHITE_RGB;
    unique case (id)
      10'd22:  rgb = 24'hFF0000;
      10'd77:  rgb = 24'hFF8000;
      10'd125: rgb = 24'hFFFF00;
      10'd191: rgb = 24'h80FF00;
      10'd209: rgb = 24'h00FF00;
      10'd255: rgb = 24'h00FF80;
      10'd357: rgb = 24'h00FFFF;
      10'd372: rgb = 24'h0080FF;
      10'd442: rgb = 24'h0000FF;
      10'd480: rgb = 24'h8000FF;
      10'd507: rgb = 24'hFF00FF;
      10'd573: rgb = 24'hFF0080;
      default: rgb = WHITE_RGB;
    endcase
    return rgb;
  endfunction

endpackage

// ===== rtl/cttm_queue.sv =====
// cttm_queue: two-entry word queue between the accepting front and the back end
// depends on cttm_pkg
`timescale 1ns / 1ps
module cttm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  cttm_pkg::item_t push_item,
  output logic           full,
  output logic           pop_valid,
  output cttm_pkg::item_t pop_item,
  input  logic           pop
);
  import cttm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/cttm_div.sv =====
// cttm_div: restoring unsigned divider, one quotient bit per cycle
// no dependencies
`timescale 1ns / 1ps
module cttm_div #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 17
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  quot_r, quot_nxt;
  logic [DEN_W:0]    rem_r, rem_nxt;
  logic [DEN_W-1:0]  den_r;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DEN_W:0]    trial;

  assign done = done_r;
  assign quot = quot_r;

  always_comb begin
    trial    = {rem_r[DEN_W-1:0], quot_r[NUM_W-1]};
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (go) begin
      quot_nxt = num;
      rem_nxt  = '0;
      step_nxt = STEP_W'(NUM_W);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt  = trial - {1'b0, den_r};
        quot_nxt = {quot_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt  = trial;
        quot_nxt = {quot_r[NUM_W-2:0], 1'b0};
      end
      step_nxt = step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (go) begin
      den_r <= den;
    end
  end

endmodule

// ===== rtl/cttm_back.sv =====
// cttm_back: tag table, point accumulation, centroid and nearest-tag search
// depends on cttm_pkg and cttm_div
`timescale 1ns / 1ps
module cttm_back #(
  parameter int TAG_SLOTS          = cttm_pkg::DEF_TAG_SLOTS,
  parameter int MAX_CLUSTER_POINTS = cttm_pkg::DEF_MAX_POINTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  cttm_pkg::item_t               item,
  output logic                          item_pop,
  input  cttm_pkg::cfg_t                cfg,
  output logic                          res_valid,
  output logic [cttm_pkg::RGB_W-1:0]    res_colour,
  output logic                          res_matched,
  output logic [cttm_pkg::ID_W-1:0]     res_tag
);
  import cttm_pkg::*;

  localparam int SLOT_W = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_CLUSTER_POINTS + 1);
  localparam int SUM_W  = POS_W + CNT_W;
  localparam int C_W    = POS_W + 1;
  localparam int D_W    = POS_W + 2;
  localparam int SQ_W   = 2 * D_W;
  localparam int D2_W   = SQ_W + 2;
  localparam int TOL2_W = 2 * TOL_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TAG_SLOTS - 1);
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_CLUSTER_POINTS);

  state_t state_r, state_nxt;

  // tag table
  logic [TAG_SLOTS-1:0]    valid_r;
  logic [ID_W-1:0]         slot_id_r   [TAG_SLOTS];
  logic signed [POS_W-1:0] slot_x_r    [TAG_SLOTS];
  logic signed [POS_W-1:0] slot_y_r    [TAG_SLOTS];
  logic signed [POS_W-1:0] slot_z_r    [TAG_SLOTS];
  logic [TIME_W-1:0]       slot_time_r [TAG_SLOTS];

  item_t                   cur_r;
  logic [SLOT_W-1:0]       idx_r;
  logic                    dup_r, free_ok_r;
  logic [SLOT_W-1:0]       free_idx_r;

  logic signed [SUM_W-1:0] sum_x_r, sum_y_r, sum_z_r;
  logic [CNT_W-1:0]        count_r;
  logic [2:0]              neg_r;
  logic signed [C_W-1:0]   cx_r, cy_r, cz_r;
  logic [TOL2_W-1:0]       tol2_r;
  logic [SQ_W-1:0]         sqx_r, sqy_r, sqz_r;
  logic                    sq_valid_r;
  logic                    found_r;
  logic [D2_W-1:0]         best_r;
  logic [ID_W-1:0]         best_id_r;

  logic                    out_valid_r;
  logic [RGB_W-1:0]        out_colour_r;
  logic                    out_matched_r;
  logic [ID_W-1:0]         out_tag_r;

  // control decode
  logic                    take, is_point, room, fire;
  logic [CNT_W-1:0]        cnt_after;
  logic                    div_go, div_done_x, div_done_y, div_done_z;
  logic [SUM_W-1:0]        qx, qy, qz;
  logic signed [SUM_W-1:0] new_x, new_y, new_z;
  logic [SUM_W-1:0]        mag_x, mag_y, mag_z;
  logic signed [D_W-1:0]   dx, dy, dz;
  logic [D2_W-1:0]         d2;
  logic [TIME_W-1:0]       age;
  logic                    better;

  assign take      = (state_r == ST_IDLE) && item_valid;
  assign item_pop  = take;
  assign is_point  = (item.command == CMD_POINT);
  assign room      = (count_r < CNT_MAX);
  assign cnt_after = room ? count_r + CNT_W'(1) : count_r;
  assign fire      = take && is_point && item.last_point && (cnt_after != '0);
  assign div_go    = fire;

  assign new_x = room ? sum_x_r + SUM_W'(item.pos_x) : sum_x_r;
  assign new_y = room ? sum_y_r + SUM_W'(item.pos_y) : sum_y_r;
  assign new_z = room ? sum_z_r + SUM_W'(item.pos_z) : sum_z_r;
  assign mag_x = new_x[SUM_W-1] ? SUM_W'(-new_x) : SUM_W'(new_x);
  assign mag_y = new_y[SUM_W-1] ? SUM_W'(-new_y) : SUM_W'(new_y);
  assign mag_z = new_z[SUM_W-1] ? SUM_W'(-new_z) : SUM_W'(new_z);

  cttm_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_x (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(mag_x), .den(cnt_after),
    .done(div_done_x), .quot(qx)
  );
  cttm_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_y (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(mag_y), .den(cnt_after),
    .done(div_done_y), .quot(qy)
  );
  cttm_div #(.NUM_W(SUM_W), .DEN_W(CNT_W)) u_div_z (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(mag_z), .den(cnt_after),
    .done(div_done_z), .quot(qz)
  );

  assign dx = D_W'(cx_r) - D_W'(slot_x_r[idx_r]);
  assign dy = D_W'(cy_r) - D_W'(slot_y_r[idx_r]);
  assign dz = D_W'(cz_r) - D_W'(slot_z_r[idx_r]);
  assign d2 = D2_W'(sqx_r) + D2_W'(sqy_r) + D2_W'(sqz_r);
  assign age = cur_r.now_ms - slot_time_r[idx_r];
  assign better = !found_r || (d2 < best_r) ||
                  ((d2 == best_r) && (slot_id_r[idx_r] < best_id_r));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          priority if (fire)                    state_nxt = ST_DIV;
          else if (item.command == CMD_TAG)     state_nxt = ST_TAG_SCAN;
          else if (item.command == CMD_SWEEP)   state_nxt = ST_SWEEP;
          else                                  state_nxt = ST_IDLE;
        end
      end
      ST_TAG_SCAN:  if (idx_r == LAST_SLOT) state_nxt = ST_IDLE;
      ST_SWEEP:     if (idx_r == LAST_SLOT) state_nxt = ST_IDLE;
      ST_DIV:       if (div_done_x) state_nxt = ST_MATCH_MUL;
      ST_MATCH_MUL: state_nxt = ST_MATCH_ACC;
      ST_MATCH_ACC: state_nxt = (idx_r == LAST_SLOT) ? ST_OUT : ST_MATCH_MUL;
      ST_OUT:       state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // result port drive
  always_comb begin
    res_valid   = out_valid_r;
    res_colour  = out_colour_r;
    res_matched = out_matched_r;
    res_tag     = out_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      sum_x_r     <= '0;
      sum_y_r     <= '0;
      sum_z_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_OUT);
      unique case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (take && is_point) begin
            sum_x_r <= new_x;
            sum_y_r <= new_y;
            sum_z_r <= new_z;
            count_r <= cnt_after;
          end
        end
        ST_TAG_SCAN: begin
          idx_r <= (idx_r == LAST_SLOT) ? '0 : idx_r + SLOT_W'(1);
          if (idx_r == LAST_SLOT) begin
            // slot chosen once the whole table has been checked for the id
            if (!dup_r && !(valid_r[idx_r] && slot_id_r[idx_r] == cur_r.tag_id)) begin
              if (free_ok_r) begin
                valid_r[free_idx_r] <= 1'b1;
              end else if (!valid_r[idx_r]) begin
                valid_r[idx_r] <= 1'b1;
              end
            end
          end
        end
        ST_SWEEP: begin
          idx_r <= (idx_r == LAST_SLOT) ? '0 : idx_r + SLOT_W'(1);
          if (valid_r[idx_r] && age >= cfg.decay) begin
            valid_r[idx_r] <= 1'b0;
          end
        end
        ST_MATCH_ACC: begin
          idx_r <= (idx_r == LAST_SLOT) ? '0 : idx_r + SLOT_W'(1);
        end
        ST_OUT: begin
          sum_x_r <= '0;
          sum_y_r <= '0;
          sum_z_r <= '0;
          count_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        dup_r     <= 1'b0;
        free_ok_r <= 1'b0;
        found_r   <= 1'b0;
        best_id_r <= '0;
        if (take) begin
          cur_r  <= item;
          neg_r  <= {new_z[SUM_W-1], new_y[SUM_W-1], new_x[SUM_W-1]};
          tol2_r <= cfg.tolerance * cfg.tolerance;
        end
      end
      ST_TAG_SCAN: begin
        if (valid_r[idx_r]) begin
          if (slot_id_r[idx_r] == cur_r.tag_id) begin
            dup_r <= 1'b1;
          end
        end else if (!free_ok_r) begin
          free_ok_r  <= 1'b1;
          free_idx_r <= idx_r;
        end
        if (idx_r == LAST_SLOT &&
            !dup_r && !(valid_r[idx_r] && slot_id_r[idx_r] == cur_r.tag_id)) begin
          if (free_ok_r) begin
            slot_id_r[free_idx_r]   <= cur_r.tag_id;
            slot_x_r[free_idx_r]    <= cur_r.pos_x;
            slot_y_r[free_idx_r]    <= cur_r.pos_y;
            slot_z_r[free_idx_r]    <= cur_r.pos_z;
            slot_time_r[free_idx_r] <= cur_r.now_ms;
          end else if (!valid_r[idx_r]) begin
            slot_id_r[idx_r]   <= cur_r.tag_id;
            slot_x_r[idx_r]    <= cur_r.pos_x;
            slot_y_r[idx_r]    <= cur_r.pos_y;
            slot_z_r[idx_r]    <= cur_r.pos_z;
            slot_time_r[idx_r] <= cur_r.now_ms;
          end
        end
      end
      ST_DIV: begin
        if (div_done_x && div_done_y && div_done_z) begin
          cx_r <= neg_r[0] ? C_W'(-qx) : C_W'(qx);
          cy_r <= neg_r[1] ? C_W'(-qy) : C_W'(qy);
          cz_r <= neg_r[2] ? C_W'(-qz) : C_W'(qz);
        end
      end
      ST_MATCH_MUL: begin
        sqx_r      <= SQ_W'(dx * dx);
        sqy_r      <= SQ_W'(dy * dy);
        sqz_r      <= SQ_W'(dz * dz);
        sq_valid_r <= valid_r[idx_r];
      end
      ST_MATCH_ACC: begin
        if (sq_valid_r && better) begin
          found_r   <= 1'b1;
          best_r    <= d2;
          best_id_r <= slot_id_r[idx_r];
        end
      end
      ST_OUT: begin
        out_tag_r <= best_id_r;
        if (found_r && (best_r < D2_W'(tol2_r))) begin
          out_matched_r <= 1'b1;
          out_colour_r  <= colour_of(best_id_r);
        end else begin
          out_matched_r <= 1'b0;
          out_colour_r  <= WHITE_RGB;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/cluster_tag_colour_matcher.sv =====
// cluster_tag_colour_matcher: top level, config registers, queue and back end
// depends on cttm_pkg, cttm_queue, cttm_back
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------
//  in      | start / busy           | in_command .. in_last_point
//  out     | out_valid (strobe)     | out_colour, out_matched, out_matched_tag
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// the back end takes a word off the queue while idle; a point ends there,
// a tag detection or sweep then scans the TAG_SLOTS slots (one slot per cycle), a last
// point runs the divider, a search that alternates multiply and accumulate per slot
// and a step that forms the result, and the strobe follows;
// a two-word queue holds words while the back end works; busy is queue full.
// reset is synchronous; the tag table valid bits clear at once, no sweep.
// results are strobed for one cycle and cannot be stalled.
`timescale 1ns / 1ps
module cluster_tag_colour_matcher #(
  parameter int TAG_SLOTS          = cttm_pkg::DEF_TAG_SLOTS,
  parameter int MAX_CLUSTER_POINTS = cttm_pkg::DEF_MAX_POINTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [cttm_pkg::CMD_W-1:0]          in_command,
  input  logic [cttm_pkg::ID_W-1:0]           in_tag_id,
  input  logic signed [cttm_pkg::POS_W-1:0]   in_pos_x,
  input  logic signed [cttm_pkg::POS_W-1:0]   in_pos_y,
  input  logic signed [cttm_pkg::POS_W-1:0]   in_pos_z,
  input  logic [cttm_pkg::TIME_W-1:0]         in_now_ms,
  input  logic                                in_last_point,
  output logic                                out_valid,
  output logic [cttm_pkg::RGB_W-1:0]          out_colour,
  output logic                                out_matched,
  output logic [cttm_pkg::ID_W-1:0]           out_matched_tag,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cttm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cttm_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cttm_pkg::*;

  cfg_t  cfg_r;
  item_t in_item, q_item;
  logic  q_full, q_valid, q_pop;

  assign cfg_ready = 1'b1;
  assign busy      = q_full;

  always_comb begin
    in_item.command    = in_command;
    in_item.tag_id     = in_tag_id;
    in_item.pos_x      = in_pos_x;
    in_item.pos_y      = in_pos_y;
    in_item.pos_z      = in_pos_z;
    in_item.now_ms     = in_now_ms;
    in_item.last_point = in_last_point;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tolerance <= TOL_RESET;
      cfg_r.decay     <= DECAY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TOLERANCE: cfg_r.tolerance <= cfg_data[TOL_W-1:0];
        REG_DECAY:     cfg_r.decay     <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  cttm_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(start), .push_item(in_item), .full(q_full),
    .pop_valid(q_valid), .pop_item(q_item), .pop(q_pop)
  );

  cttm_back #(
    .TAG_SLOTS(TAG_SLOTS), .MAX_CLUSTER_POINTS(MAX_CLUSTER_POINTS)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .item_valid(q_valid), .item(q_item), .item_pop(q_pop),
    .cfg(cfg_r),
    .res_valid(out_valid), .res_colour(out_colour),
    .res_matched(out_matched), .res_tag(out_matched_tag)
  );

endmodule

// ===== rtl/cttm_chk.sv =====
// cttm_chk: port-level checks for cluster_tag_colour_matcher, bound to the top
// depends on cttm_pkg
`timescale 1ns / 1ps
module cttm_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic                           out_valid,
  input logic [cttm_pkg::RGB_W-1:0]     out_colour,
  input logic                           out_matched,
  input logic                           cfg_valid,
  input logic                           cfg_ready
);
  import cttm_pkg::*;

  // a result needs a full divide and search, never two strobes in a row
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("back to back result strobes");

  a_white_unmatched: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_matched) |-> (out_colour == WHITE_RGB))
    else $error("unmatched result is not white");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready) else $error("config write refused");

  // queue of two: a single word into an empty block cannot fill it
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start)) else $error("busy rose without a word");

endmodule

bind cluster_tag_colour_matcher cttm_chk u_cttm_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_colour(out_colour), .out_matched(out_matched),
  .cfg_valid(cfg_valid), .cfg_ready(cfg_ready)
);

// ===== tb/tb_cluster_tag_colour_matcher.sv =====
// tb_cluster_tag_colour_matcher: self-checking bench for the cluster/tag matcher,
// a directed table and then random tag, sweep, unused-command and cluster traffic checked by a predictor
// depends on cttm_pkg and cluster_tag_colour_matcher
`timescale 1ns / 1ps
module tb_cluster_tag_colour_matcher;
  import cttm_pkg::*;

  localparam int SLOTS = DEF_TAG_SLOTS;
  localparam int TIMEOUT_CYCLES = 2000000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [RGB_W-1:0] colour;
    logic             matched;
    logic [ID_W-1:0]  tag;
  } result_t;

  typedef struct {
    item_t   it;
    bit      chk;
    result_t res;
  } row_t;

  logic clk = 0, rst_n = 0, start = 0;
  logic busy, out_valid, out_matched, cfg_valid = 0, cfg_ready;
  logic [CMD_W-1:0] in_command = '0;
  logic [ID_W-1:0] in_tag_id = '0, out_matched_tag;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic [TIME_W-1:0] in_now_ms = '0;
  logic in_last_point = 0;
  logic [RGB_W-1:0] out_colour;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cluster_tag_colour_matcher dut (.*);

  // predictor state
  logic [TOL_W-1:0] tol_mm;
  logic [TIME_W-1:0] decay_ms;
  bit tag_live[SLOTS];
  logic [ID_W-1:0] tag_ident[SLOTS];
  longint tag_xyz[SLOTS][3];
  logic [TIME_W-1:0] tag_stamp[SLOTS];
  longint point_sum[3];
  int unsigned pts_in_cluster;
  result_t colour_q[$];

  int errors = 0;
  int unsigned cycles = 0;
  bit quiet = 0;
  logic [TIME_W-1:0] clock_ms = 0;

  const logic [ID_W-1:0] known_ids[12] = '{22, 77, 125, 191, 209, 255, 357, 372, 442, 480,
                                           507, 573};
  const logic [RGB_W-1:0] known_rgb[12] = '{24'hFF0000, 24'hFF8000, 24'hFFFF00, 24'h80FF00,
                                            24'h00FF00, 24'h00FF80, 24'h00FFFF, 24'h0080FF,
                                            24'h0000FF, 24'h8000FF, 24'hFF00FF, 24'hFF0080};

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (colour_q.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        result_t e;
        e = colour_q.pop_front();
        if (out_colour !== e.colour) begin
          $error("colour expected %h actual %h", e.colour, out_colour);
          errors++;
        end
        if (out_matched !== e.matched) begin
          $error("matched expected %0d actual %0d", e.matched, out_matched);
          errors++;
        end
        if (out_matched_tag !== e.tag) begin
          $error("matched_tag expected %0d actual %0d", e.tag, out_matched_tag);
          errors++;
        end
      end
    end
  end

  function automatic result_t match_centroid();
    result_t r;
    longint c[3];
    longint unsigned best, d2, tol2;
    logic [ID_W-1:0] best_id;
    bit found;
    longint d;
    best = 0;
    best_id = '0;
    found = 0;
    for (int k = 0; k < 3; k++) c[k] = point_sum[k] / longint'(pts_in_cluster);
    for (int i = 0; i < SLOTS; i++) begin
      if (tag_live[i]) begin
        d2 = 0;
        for (int k = 0; k < 3; k++) begin
          d = c[k] - tag_xyz[i][k];
          if (d < 0) d = -d;
          d2 += longint'(d) * longint'(d);
        end
        if (!found || d2 < best || (d2 == best && tag_ident[i] < best_id)) begin
          found = 1;
          best = d2;
          best_id = tag_ident[i];
        end
      end
    end
    tol2 = longint'(tol_mm) * longint'(tol_mm);
    r.colour = WHITE_RGB;
    r.matched = 0;
    if (found && best < tol2) begin
      r.matched = 1;
      for (int j = 0; j < 12; j++) if (known_ids[j] == best_id) r.colour = known_rgb[j];
    end
    r.tag = best_id;
    return r;
  endfunction

  // advance the predictor by one accepted word; typed results override the prediction
  task automatic predict_word(input item_t it, input bit chk, input result_t typed);
    int free_slot;
    bit dup;
    result_t r;
    case (it.command)
      CMD_POINT: begin
        if (pts_in_cluster < DEF_MAX_POINTS) begin
          point_sum[0] += longint'(it.pos_x);
          point_sum[1] += longint'(it.pos_y);
          point_sum[2] += longint'(it.pos_z);
          pts_in_cluster++;
        end
        if (it.last_point && pts_in_cluster > 0) begin
          r = match_centroid();
          colour_q.push_back(chk ? typed : r);
          point_sum = '{0, 0, 0};
          pts_in_cluster = 0;
        end
      end
      CMD_TAG: begin
        free_slot = -1;
        dup = 0;
        for (int i = 0; i < SLOTS; i++) begin
          if (tag_live[i]) begin
            if (tag_ident[i] == it.tag_id) dup = 1;
          end else if (free_slot < 0) free_slot = i;
        end
        if (!dup && free_slot >= 0) begin
          tag_live[free_slot] = 1;
          tag_ident[free_slot] = it.tag_id;
          tag_xyz[free_slot] = '{longint'(it.pos_x), longint'(it.pos_y), longint'(it.pos_z)};
          tag_stamp[free_slot] = it.now_ms;
        end
      end
      CMD_SWEEP: begin
        for (int i = 0; i < SLOTS; i++)
          if (tag_live[i] && TIME_W'(it.now_ms - tag_stamp[i]) >= decay_ms) tag_live[i] = 0;
      end
      default: ;
    endcase
  endtask

  // called at a falling edge; returns at a falling edge once busy is low, leaving start high
  task automatic send_word(input item_t it, input bit chk = 0, input result_t typed = '{0, 0, 0});
    start <= 1;
    in_command <= it.command;
    in_tag_id <= it.tag_id;
    in_pos_x <= it.pos_x;
    in_pos_y <= it.pos_y;
    in_pos_z <= it.pos_z;
    in_now_ms <= it.now_ms;
    in_last_point <= it.last_point;
    do @(posedge clk); while (busy);
    predict_word(it, chk, typed);
    @(negedge clk);
  endtask

  task automatic hold_off(input int n);
    start <= 0;
    repeat (n) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 18));
  endtask

  // tags, sweeps and points that are not last give no result, so the back end may still be working after the last one
  task automatic drain();
    start <= 0;
    while (colour_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_TOLERANCE) tol_mm = val[TOL_W-1:0];
    else if (idx == REG_DECAY) decay_ms = val;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  function automatic item_t mk(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id, int x, int y, int z,
                               logic [TIME_W-1:0] now, logic last);
    item_t it;
    it.command = cmd;
    it.tag_id = id;
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.pos_z = POS_W'(z);
    it.now_ms = now;
    it.last_point = last;
    return it;
  endfunction

  function automatic int clip(int v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  function automatic int any_pos();
    return int'($urandom_range(0, 262143)) - 131072;
  endfunction

  task automatic random_word();
    int kind, n, live_n, pick;
    int cx, cy, cz, spread;
    logic [ID_W-1:0] id;
    kind = $urandom_range(0, 99);
    if (kind < 28) begin
      case ($urandom_range(0, 3))
        0: id = known_ids[$urandom_range(0, 11)];
        1: id = ID_W'($urandom);
        default: id = ID_W'($urandom_range(0, 31));
      endcase
      clock_ms += $urandom_range(0, 300);
      maybe_gap();
      if ($urandom_range(0, 9) == 0)
        send_word(mk(CMD_TAG, id, any_pos(), any_pos(), any_pos(), $urandom, 1'($urandom)));
      else
        send_word(mk(CMD_TAG, id, $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                     $urandom_range(0, 4000) - 2000, clock_ms, 1'($urandom)));
    end else if (kind < 38) begin
      clock_ms += $urandom_range(0, 1500);
      maybe_gap();
      send_word(mk(CMD_SWEEP, ID_W'($urandom), any_pos(), any_pos(), any_pos(),
                   ($urandom_range(0, 9) == 0) ? $urandom : clock_ms, 1'($urandom)));
    end else if (kind < 41) begin
      maybe_gap();
      send_word(mk(CMD_UNUSED, ID_W'($urandom), any_pos(), any_pos(), any_pos(), $urandom,
                   1'($urandom)));
    end else if (kind < 47) begin
      maybe_gap();
      send_word(mk(CMD_POINT, ID_W'($urandom), any_pos(), any_pos(), any_pos(), $urandom,
                   1'($urandom)));
    end else begin
      // cluster around a stored tag, or somewhere random
      live_n = 0;
      for (int i = 0; i < SLOTS; i++) if (tag_live[i]) live_n++;
      cx = $urandom_range(0, 4000) - 2000;
      cy = $urandom_range(0, 4000) - 2000;
      cz = $urandom_range(0, 4000) - 2000;
      if (live_n > 0 && $urandom_range(0, 4) != 0) begin
        pick = $urandom_range(0, live_n - 1);
        for (int i = 0; i < SLOTS; i++) begin
          if (tag_live[i]) begin
            if (pick == 0) begin
              cx = int'(tag_xyz[i][0]);
              cy = int'(tag_xyz[i][1]);
              cz = int'(tag_xyz[i][2]);
            end
            pick--;
          end
        end
      end
      n = $urandom_range(1, 6);
      spread = $urandom_range(0, 400);
      for (int p = 0; p < n; p++) begin
        maybe_gap();
        send_word(mk(CMD_POINT, ID_W'($urandom),
                     clip(cx + $urandom_range(0, 2 * spread) - spread),
                     clip(cy + $urandom_range(0, 2 * spread) - spread),
                     clip(cz + $urandom_range(0, 2 * spread) - spread),
                     $urandom, p == n - 1));
      end
    end
  endtask

  row_t dir[$];
  int sent;

  initial begin
    tol_mm = TOL_RESET;
    decay_ms = DECAY_RESET;
    foreach (tag_live[i]) tag_live[i] = 0;
    point_sum = '{0, 0, 0};
    pts_in_cluster = 0;

    dir.push_back('{mk(CMD_POINT, 0, 5, 5, 5, 0, 1), 1, '{WHITE_RGB, 0, 0}});
    dir.push_back('{mk(CMD_TAG, 22, 0, 0, 0, 100, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_TAG, 22, 9000, 0, 0, 200, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_POINT, 0, 10, 0, 0, 0, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_POINT, 0, 30, 0, 0, 0, 1), 1, '{24'hFF0000, 1, 22}});
    dir.push_back('{mk(CMD_TAG, 1023, 131071, 131071, 131071, 300, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_POINT, 0, 131071, 131071, 131071, 0, 1), 1, '{WHITE_RGB, 1, 1023}});
    dir.push_back('{mk(CMD_TAG, 0, -131072, -131072, -131072, 32'hFFFF_FFFF, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_POINT, 0, -131072, -131072, -131072, 0, 1), 1, '{WHITE_RGB, 1, 0}});
    dir.push_back('{mk(CMD_TAG, 573, -1000, 0, 0, 400, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_TAG, 480, 1000, 0, 0, 400, 0), 0, '{0, 0, 0}});
    // backwards time on tag 0 looks old, tag 22 is exactly at the decay age
    dir.push_back('{mk(CMD_SWEEP, 0, 0, 0, 0, 2100, 0), 0, '{0, 0, 0}});
    // equal distance to 480 and 573, lower id wins, outside tolerance
    dir.push_back('{mk(CMD_POINT, 0, 0, 0, 0, 0, 1), 1, '{WHITE_RGB, 0, 480}});
    dir.push_back('{mk(CMD_UNUSED, 5, 0, 0, 0, 0, 1), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_TAG, 125, 0, 0, 249, 2100, 1), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_POINT, 0, 0, 0, 0, 0, 1), 1, '{24'hFFFF00, 1, 125}});
    dir.push_back('{mk(CMD_POINT, 0, -3, 0, 0, 0, 0), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_POINT, 0, 0, 0, 0, 0, 1), 0, '{0, 0, 0}});
    dir.push_back('{mk(CMD_SWEEP, 0, 0, 0, 0, 32'hFFFF_FFFF, 0), 0, '{0, 0, 0}});

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (2) @(negedge clk);

    foreach (dir[i]) send_word(dir[i].it, dir[i].chk, dir[i].res);
    clock_ms = 32'hFFFF_F000;

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          cfg_write(REG_TOLERANCE, 0);
          cfg_write(REG_DECAY, 32'hFFFF_FFFF);
        end
        1: begin
          cfg_write(REG_TOLERANCE, 131071);
          cfg_write(REG_DECAY, 1);
        end
        2: begin
          cfg_write(REG_TOLERANCE, 300);
          cfg_write(REG_DECAY, 2500);
        end
        5: begin
          cfg_write(REG_TOLERANCE, $urandom_range(100, 800));
          cfg_write(REG_DECAY, $urandom_range(500, 4000));
          quiet = 1;
        end
        default: begin
          cfg_write(REG_TOLERANCE, $urandom);
          cfg_write(REG_DECAY, $urandom);
        end
      endcase
      sent = 0;
      while (sent < 225) begin
        random_word();
        sent++;
      end
    end

    drain();
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/cttm_pkg.sv
rtl/cttm_queue.sv
rtl/cttm_div.sv
rtl/cttm_back.sv
rtl/cluster_tag_colour_matcher.sv
rtl/cttm_chk.sv
tb/tb_cluster_tag_colour_matcher.sv
